// ----- hdl/sb64_pkg.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder package
// Shared types, codes and the alphabet lookup of the strict base64 decoder.
// ----------------------------------------------------------------------------
package sb64_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEWLINE  = 2'd1,
    ST_BAD_CHAR = 2'd2,
    ST_BAD_PAD  = 2'd3
  } status_e;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One command for the back end: up to three data bytes, then an optional status.
  typedef struct packed {
    logic [1:0]      n_bytes;
    logic [0:2][7:0] bytes;
    logic            has_status;
    status_e         status;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.valid = 1'b1;
    r.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      r.value = 6'd62;
    end else if (c == CHAR_SLASH) begin
      r.value = 6'd63;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/sb64_if.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder channels
// Valid/ready channels for text characters in and decoded items out.
// ----------------------------------------------------------------------------
interface sb64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface sb64_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       end_of_run;

  modport source (output valid, output kind, output data_byte, output status,
                  output end_of_run, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input end_of_run, output ready);
endinterface

// ----- hdl/sb64_front.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, tracks group and padding state, and issues one
// command per character that yields output.
// ----------------------------------------------------------------------------
module sb64_front import sb64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sb64_in_if.sink    in_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [17:0] gb_q, gb_d, gb_n;
  logic [1:0]  gc_q, gc_d, gc_n;
  logic        ps_q, ps_d, ps_n;
  logic [1:0]  pc_q, pc_d, pc_n;
  logic        bad_q, bad_d, bad_n;
  logic        accept;
  logic        full_grp;
  logic        bad_len;
  sextet_t     sx;
  logic [23:0] word;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign sx         = sextet_of(in_i.char_code);
  assign word       = {gb_q, sx.value};

  always_comb begin
    gb_n     = gb_q;
    gc_n     = gc_q;
    ps_n     = ps_q;
    pc_n     = pc_q;
    bad_n    = bad_q;
    full_grp = 1'b0;
    if (ps_q) begin
      if (pc_q != 2'd3) begin
        pc_n = pc_q + 2'd1;
      end
    end else if (in_i.char_code == CHAR_PAD) begin
      ps_n = 1'b1;
      pc_n = 2'd1;
    end else if (!sx.valid) begin
      bad_n = 1'b1;
    end else if (gc_q == 2'd3) begin
      full_grp = 1'b1;
      gb_n     = '0;
      gc_n     = 2'd0;
    end else begin
      gb_n = {gb_q[11:0], sx.value};
      gc_n = gc_q + 2'd1;
    end
  end

  always_comb begin
    bad_len = (pc_n == 2'd3) || (gc_n == 2'd1) ||
              (pc_n == 2'd0 && gc_n != 2'd0) ||
              (pc_n == 2'd2 && gc_n != 2'd2) ||
              (pc_n == 2'd1 && gc_n != 2'd3);

    cmd_o            = '0;
    cmd_o.has_status = in_i.last;
    if (in_i.char_code == CHAR_NEWLINE) begin
      cmd_o.status = ST_NEWLINE;
    end else if (bad_n) begin
      cmd_o.status = ST_BAD_CHAR;
    end else if (bad_len) begin
      cmd_o.status = ST_BAD_PAD;
    end else begin
      cmd_o.status = ST_OK;
    end

    if (full_grp && !bad_q) begin
      cmd_o.n_bytes  = 2'd3;
      cmd_o.bytes[0] = word[23:16];
      cmd_o.bytes[1] = word[15:8];
      cmd_o.bytes[2] = word[7:0];
    end else if (in_i.last && cmd_o.status == ST_OK && gc_n == 2'd2) begin
      cmd_o.n_bytes  = 2'd1;
      cmd_o.bytes[0] = gb_n[11:4];
    end else if (in_i.last && cmd_o.status == ST_OK && gc_n == 2'd3) begin
      cmd_o.n_bytes  = 2'd2;
      cmd_o.bytes[0] = gb_n[17:10];
      cmd_o.bytes[1] = gb_n[9:2];
    end

    push_o = accept && (cmd_o.n_bytes != 2'd0 || in_i.last);

    gb_d  = gb_q;
    gc_d  = gc_q;
    ps_d  = ps_q;
    pc_d  = pc_q;
    bad_d = bad_q;
    if (accept) begin
      if (in_i.last) begin
        gb_d  = '0;
        gc_d  = 2'd0;
        ps_d  = 1'b0;
        pc_d  = 2'd0;
        bad_d = 1'b0;
      end else begin
        gb_d  = gb_n;
        gc_d  = gc_n;
        ps_d  = ps_n;
        pc_d  = pc_n;
        bad_d = bad_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q  <= '0;
      gc_q  <= 2'd0;
      ps_q  <= 1'b0;
      pc_q  <= 2'd0;
      bad_q <= 1'b0;
    end else begin
      gb_q  <= gb_d;
      gc_q  <= gc_d;
      ps_q  <= ps_d;
      pc_q  <= pc_d;
      bad_q <= bad_d;
    end
  end

endmodule

// ----- hdl/sb64_queue.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module sb64_queue import sb64_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/sb64_back.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Unpacks each queued command into data and status items, one per cycle while
// the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module sb64_back import sb64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  sb64_out_if.source out_o
);

  logic       ov_q, ov_d;
  logic [1:0] sub_q, sub_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] st_q, st_d;
  logic       eor_q, eor_d;
  logic       load;
  logic       last_item;
  logic [2:0] total;

  assign out_o.valid      = ov_q;
  assign out_o.kind       = kind_q;
  assign out_o.data_byte  = byte_q;
  assign out_o.status     = st_q;
  assign out_o.end_of_run = eor_q;

  assign load      = !empty_i && (!ov_q || out_o.ready);
  assign total     = {1'b0, head_i.n_bytes} + {2'b0, head_i.has_status};
  assign last_item = ({1'b0, sub_q} + 3'd1) == total;
  assign pop_o     = load && last_item;

  always_comb begin
    ov_d   = ov_q;
    sub_d  = sub_q;
    kind_d = kind_q;
    byte_d = byte_q;
    st_d   = st_q;
    eor_d  = eor_q;
    if (load) begin
      ov_d  = 1'b1;
      sub_d = last_item ? 2'd0 : sub_q + 2'd1;
      if (sub_q < head_i.n_bytes) begin
        kind_d = KIND_DATA;
        st_d   = ST_OK;
        eor_d  = 1'b0;
        unique case (sub_q)
          2'd0:    byte_d = head_i.bytes[0];
          2'd1:    byte_d = head_i.bytes[1];
          default: byte_d = head_i.bytes[2];
        endcase
      end else begin
        kind_d = KIND_STATUS;
        byte_d = 8'h00;
        st_d   = head_i.status;
        eor_d  = 1'b1;
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    st_q   <= st_d;
    eor_q  <= eor_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      sub_q <= 2'd0;
    end else begin
      ov_q  <= ov_d;
      sub_q <= sub_d;
    end
  end

endmodule

// ----- hdl/strict_base64_decoder.sv -----
// ----------------------------------------------------------------------------
// Strict base64 decoder
// Decodes a base64 text field, one character per item, into data bytes and a
// closing status item.
//
//   Channel  Dir  Payload                                  Item
//   in_i     in   char_code[7:0], last                     one text character
//   out_o    out  kind, data_byte[7:0], status[1:0],       one byte or status
//                 end_of_run
//
// The front end takes one character per cycle while its four-entry command
// queue has room. The back end emits one result item per cycle unless the
// output stalls, so a character that completes a group yields three items,
// which the queue absorbs. An accepted command passes through the queue into
// the output register. Reset clears the group state, the queue and the output
// valid. A stalled output fills the queue and then holds ready low on the input.
// ----------------------------------------------------------------------------
module strict_base64_decoder import sb64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sb64_in_if.sink    in_i,
  sb64_out_if.source out_o
);

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t cmd;
  cmd_t head;

  sb64_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  sb64_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  sb64_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- hdl/sb64_checker.sv -----
// ----------------------------------------------------------------------------
// Base64 decoder checker
// Port-level checks on the decoder output, bound to the top level.
// ----------------------------------------------------------------------------
module sb64_checker import sb64_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_kind_i,
  input logic [7:0] out_data_byte_i,
  input logic [1:0] out_status_i,
  input logic       out_end_of_run_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output item dropped while stalled.");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_DATA |->
      out_status_i == ST_OK && !out_end_of_run_i)
    else $error("Data item carries status fields.");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_STATUS |->
      out_data_byte_i == 8'h00 && out_end_of_run_i)
    else $error("Status item malformed.");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("Output valid during reset.");

endmodule

bind strict_base64_decoder sb64_checker u_sb64_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_data_byte_i  (out_o.data_byte),
  .out_status_i     (out_o.status),
  .out_end_of_run_i (out_o.end_of_run)
);

// ----- tb/tb_strict_base64_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Strict base64 decoder testbench
// Sends base64 text fields one character per item, first a few hand-picked
// fields and then randomly encoded and corrupted ones, with random sender
// bursts and receiver stalls. Every character accepted is run through a
// behavioral decoder whose byte and status items are compared in order with
// the items the block returns.
// ----------------------------------------------------------------------------
module tb_strict_base64_decoder import sb64_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_char_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    status_e    status;
    logic       end_of_run;
  } decoded_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sb64_in_if  char_ch ();
  sb64_out_if res_ch ();

  strict_base64_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (res_ch)
  );

  text_char_t    text_q[$];
  decoded_item_t decoded_q[$];
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left;
  int unsigned   gap_left;
  logic [15:0]   stall_pattern;
  logic [3:0]    stall_phase;

  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_count = '0;
  logic        pad_on = 1'b0;
  logic [1:0]  pad_run = '0;
  logic        bad_char = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == CHAR_PLUS) return 62;
    if (c == CHAR_SLASH) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 26);
    if (v < 6'd62) return 8'("0" + v - 52);
    if (v == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic void predict_char(input logic [7:0] c, input logic last);
    int          v;
    logic [23:0] word;
    logic [1:0]  pads;
    logic        bad_len;
    status_e     st;
    if (pad_on) begin
      if (pad_run != 2'd3) pad_run = pad_run + 2'd1;
    end else if (c == CHAR_PAD) begin
      pad_on = 1'b1;
      pad_run = 2'd1;
    end else begin
      v = sextet_value(c);
      if (v < 0) begin
        bad_char = 1'b1;
      end else if (grp_count == 2'd3) begin
        word = {grp_bits, v[5:0]};
        if (!bad_char) begin
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, word[23:16], ST_OK, 1'b0});
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, word[15:8], ST_OK, 1'b0});
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, word[7:0], ST_OK, 1'b0});
        end
        grp_bits = '0;
        grp_count = '0;
      end else begin
        grp_bits = {grp_bits[11:0], v[5:0]};
        grp_count = grp_count + 2'd1;
      end
    end
    if (last) begin
      pads = pad_on ? pad_run : 2'd0;
      bad_len = (pads == 2'd3) || (grp_count == 2'd1) ||
                (pads == 2'd0 && grp_count != 2'd0) ||
                (pads == 2'd2 && grp_count != 2'd2) ||
                (pads == 2'd1 && grp_count != 2'd3);
      if (c == CHAR_NEWLINE) st = ST_NEWLINE;
      else if (bad_char) st = ST_BAD_CHAR;
      else if (bad_len) st = ST_BAD_PAD;
      else st = ST_OK;
      if (st == ST_OK) begin
        if (grp_count == 2'd2) begin
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, grp_bits[11:4], ST_OK, 1'b0});
        end else if (grp_count == 2'd3) begin
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, grp_bits[17:10], ST_OK, 1'b0});
          decoded_q.insert(decoded_q.size(), '{KIND_DATA, grp_bits[9:2], ST_OK, 1'b0});
        end
      end
      decoded_q.insert(decoded_q.size(), '{KIND_STATUS, 8'h00, st, 1'b1});
      grp_bits = '0;
      grp_count = '0;
      pad_on = 1'b0;
      pad_run = '0;
      bad_char = 1'b0;
    end
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_q.insert(text_q.size(), '{8'(s[i]), i == s.len() - 1});
    end
  endtask

  task automatic add_random_field();
    logic [7:0]  raw[$];
    logic [7:0]  field[$];
    logic [23:0] w;
    int          n;
    int          mode;
    n = $urandom_range(1, 7);
    repeat (n) raw.insert(raw.size(), 8'($urandom_range(0, 255)));
    // Missing bytes of a short group are random so that the unused tail
    // bits carry junk.
    for (int i = 0; i < n; i += 3) begin
      w = {raw[i], (i + 1 < n) ? raw[i + 1] : 8'($urandom),
           (i + 2 < n) ? raw[i + 2] : 8'($urandom)};
      field.insert(field.size(), alphabet_char(w[23:18]));
      field.insert(field.size(), alphabet_char(w[17:12]));
      field.insert(field.size(), (i + 1 < n) ? alphabet_char(w[11:6]) : CHAR_PAD);
      field.insert(field.size(), (i + 2 < n) ? alphabet_char(w[5:0]) : CHAR_PAD);
    end
    mode = $urandom_range(0, 11);
    case (mode)
      0: field[$urandom_range(0, field.size() - 1)] = 8'($urandom_range(0, 255));
      1: void'(field.pop_back());
      2: field.insert(field.size(), CHAR_PAD);
      3: field.insert(field.size(), CHAR_NEWLINE);
      4: begin
        field.delete();
        repeat ($urandom_range(1, 6)) field.insert(field.size(), 8'($urandom_range(0, 255)));
      end
      5: field.insert($urandom_range(0, field.size()), 8'($urandom_range(0, 255)));
      default: ;
    endcase
    for (int i = 0; i < field.size(); i++) begin
      text_q.insert(text_q.size(), '{field[i], i == field.size() - 1});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_text
    text_char_t nxt;
    logic       hold;
    if (!rst_ni) begin
      char_ch.valid <= 1'b0;
      char_ch.char_code <= '0;
      char_ch.last <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        predict_char(char_ch.char_code, char_ch.last);
      end
      hold = char_ch.valid && !char_ch.ready;
      if (!hold) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          char_ch.valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          nxt = text_q.pop_front();
          char_ch.valid <= 1'b1;
          char_ch.char_code <= nxt.char_code;
          char_ch.last <= nxt.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          char_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    decoded_item_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_pattern <= '1;
      stall_phase <= '0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected item: kind %0d data_byte %h status %0d end_of_run %0d",
                 res_ch.kind, res_ch.data_byte, res_ch.status, res_ch.end_of_run);
          fail_count++;
        end else begin
          want = decoded_q.pop_front();
          if (res_ch.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, res_ch.kind);
            fail_count++;
          end
          if (res_ch.data_byte !== want.data_byte) begin
            $error("data_byte: expected %h, actual %h", want.data_byte, res_ch.data_byte);
            fail_count++;
          end
          if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            fail_count++;
          end
          if (res_ch.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0d, actual %0d", want.end_of_run,
                   res_ch.end_of_run);
            fail_count++;
          end
        end
      end
      res_ch.ready <= stall_pattern[stall_phase];
      if (stall_phase == 4'd15) begin
        stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      end
      stall_phase <= stall_phase + 4'd1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;

    push_text("Az+/");
    push_text("Z9a=");
    push_text("QQ=\377");
    text_q.insert(text_q.size(), '{8'h00, 1'b0});
    push_text("AAAA");
    push_text("AAAA\n");
    push_text("A");

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The sender holds back until the directed fields have fully drained.
    @(negedge clk_i);
    while (text_q.size() != 0 || char_ch.valid || decoded_q.size() != 0) begin
      @(negedge clk_i);
    end

    while (text_q.size() < 100) add_random_field();

    @(negedge clk_i);
    while (text_q.size() != 0 || char_ch.valid || decoded_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sb64_pkg.sv
hdl/sb64_if.sv
hdl/sb64_front.sv
hdl/sb64_queue.sv
hdl/sb64_back.sv
hdl/strict_base64_decoder.sv
hdl/sb64_checker.sv
tb/tb_strict_base64_decoder.sv
